FILE: rtl/core/idq_pkg.sv
// Shared types and codes for the indexed deque.
package idq_pkg;

   localparam int MAX_DEPTH   = 64;
   localparam int SPAN_W      = $clog2(MAX_DEPTH + 1);
   localparam int DEF_DEPTH   = 64;
   localparam int DEF_VALUE_W = 64;

   typedef enum logic [2:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_TAIL  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_CLEAR      = 3'd4,
      KIND_GET        = 3'd5,
      KIND_RANGE      = 3'd6
   } kind_type;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic              miss;
      logic [SPAN_W-1:0] first_off;
      logic [SPAN_W-1:0] last_off;
   } span_type;

endpackage

FILE: rtl/core/idq_ram.sv
// Generic simple dual-port RAM with registered read.
module idq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/idq_index.sv
// Index normalisation and clamping for get and range reads.
module idq_index
   import idq_pkg::*;
(
   input  logic                    is_range,
   input  logic signed [15:0]      first_index,
   input  logic signed [15:0]      end_index,
   input  logic [SPAN_W-1:0]       count,
   output span_type                span
);

   logic signed [17:0] n_s;
   logic signed [17:0] a_s;
   logic signed [17:0] b_s;
   logic signed [17:0] a_adj;
   logic signed [17:0] b_adj;
   logic signed [17:0] a_clamp;
   logic signed [17:0] b_clamp;
   logic signed [17:0] b_stop;
   logic               get_miss;
   logic               range_miss;

   assign n_s = signed'(18'(count));
   assign a_s = 18'(first_index);
   assign b_s = 18'(end_index);

   assign a_adj   = (a_s < 0) ? a_s + n_s : a_s;
   assign b_adj   = (b_s < 0) ? b_s + n_s : b_s;
   assign a_clamp = (a_adj < 0) ? 18'sd0 : a_adj;
   assign b_clamp = (b_adj < 0) ? 18'sd0 : b_adj;
   assign b_stop  = (b_clamp >= n_s) ? n_s - 18'sd1 : b_clamp;

   assign get_miss   = (count == '0) || (a_adj < 0) || (a_adj >= n_s);
   assign range_miss = (count == '0) || (a_clamp >= n_s) || (a_clamp > b_stop);

   always_comb begin
      if (is_range) begin
         span.miss      = range_miss;
         span.first_off = a_clamp[SPAN_W-1:0];
         span.last_off  = b_stop[SPAN_W-1:0];
      end else begin
         span.miss      = get_miss;
         span.first_off = a_adj[SPAN_W-1:0];
         span.last_off  = a_adj[SPAN_W-1:0];
      end
   end

endmodule

FILE: rtl/core/indexed_deque_with_range_read.sv
// Top level of the indexed deque: sequencer, ring pointers and slot memory.
//
// Bounded deque kept as a ring in one RAM. An operation is taken when start is
// high and busy is low. Push, clear and rejected operations answer from S_EVAL;
// pop and get go on to S_READ, which waits for the registered RAM read; a range
// stays in S_READ for one RAM read per element. Each result word is
// shown on the rsp_ ports for one cycle with rsp_strobe high and must be
// captured then; rsp_last marks the final word of an operation. The final word
// may still be on the ports in the cycle the next operation is taken.
module indexed_deque_with_range_read
   import idq_pkg::*;
#(
   parameter int DEPTH       = DEF_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic [63:0]        req_payload,
   input  logic signed [15:0] req_first_index,
   input  logic signed [15:0] req_end_index,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [63:0]        rsp_data_out,
   output logic               rsp_last,
   output logic [6:0]         rsp_fill_level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EVAL = 3'b010,
      S_READ = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]   stop_ff, stop_in;
   kind_type           kind_ff;
   logic [VALUE_WIDTH-1:0] payload_ff;
   logic signed [15:0] first_ff;
   logic signed [15:0] end_ff;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [6:0]         rsp_fill_ff, rsp_fill_in;

   span_type           span;
   logic [CNT_W-1:0]   off_sel;
   logic [PTR_W:0]     pos_sum;
   logic [PTR_W-1:0]   pos_addr;
   logic [PTR_W-1:0]   head_dec;
   logic [PTR_W-1:0]   head_inc;
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic               accept;
   logic               full;
   logic               empty;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == FULL_C);
   assign empty  = (count_ff == '0);

   idq_index u_index (
      .is_range    (kind_ff == KIND_RANGE),
      .first_index (first_ff),
      .end_index   (end_ff),
      .count       (SPAN_W'(count_ff)),
      .span        (span)
   );

   assign pos_sum  = {1'b0, head_ff} + (PTR_W + 1)'(off_sel);
   assign pos_addr = (pos_sum >= DEPTH_P) ? PTR_W'(pos_sum - DEPTH_P) : PTR_W'(pos_sum);
   assign head_dec = (head_ff == '0) ? LAST_P : head_ff - PTR_W'(1);
   assign head_inc = (head_ff == LAST_P) ? '0 : head_ff + PTR_W'(1);
   assign wr_addr  = (kind_ff == KIND_PUSH_FRONT) ? head_dec : pos_addr;

   idq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (payload_ff),
      .rd_addr (pos_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      stop_in       = stop_ff;
      off_sel       = '0;
      wr_en         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_fill_in   = rsp_fill_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_data_in   = '0;
            rsp_last_in   = 1'b1;
            rsp_fill_in   = 7'(count_ff);
            case (kind_ff)
               KIND_PUSH_FRONT: begin
                  if (full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     wr_en       = 1'b1;
                     head_in     = head_dec;
                     count_in    = count_ff + CNT_W'(1);
                     rsp_fill_in = 7'(count_ff + CNT_W'(1));
                  end
               end
               KIND_PUSH_TAIL: begin
                  off_sel = count_ff;
                  if (full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     wr_en       = 1'b1;
                     count_in    = count_ff + CNT_W'(1);
                     rsp_fill_in = 7'(count_ff + CNT_W'(1));
                  end
               end
               KIND_POP_FRONT, KIND_POP_BACK: begin
                  if (empty) begin
                     rsp_status_in = STATUS_MISS;
                  end else begin
                     rsp_strobe_in = 1'b0;
                     state_in      = S_READ;
                     count_in      = count_ff - CNT_W'(1);
                     cur_in        = '0;
                     stop_in       = '0;
                     if (kind_ff == KIND_POP_FRONT) begin
                        head_in = head_inc;
                     end else begin
                        off_sel = count_ff - CNT_W'(1);
                     end
                  end
               end
               KIND_CLEAR: begin
                  count_in    = '0;
                  head_in     = '0;
                  rsp_fill_in = '0;
               end
               KIND_GET, KIND_RANGE: begin
                  if (span.miss) begin
                     rsp_status_in = STATUS_MISS;
                  end else begin
                     rsp_strobe_in = 1'b0;
                     state_in      = S_READ;
                     off_sel       = CNT_W'(span.first_off);
                     cur_in        = CNT_W'(span.first_off);
                     stop_in       = CNT_W'(span.last_off);
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_data_in   = 64'(rd_data);
            rsp_last_in   = (cur_ff == stop_ff);
            rsp_fill_in   = 7'(count_ff);
            if (cur_ff == stop_ff) begin
               state_in = S_IDLE;
            end else begin
               cur_in  = cur_ff + CNT_W'(1);
               off_sel = cur_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= kind_type'(req_kind);
         payload_ff <= req_payload[VALUE_WIDTH-1:0];
         first_ff   <= req_first_index;
         end_ff     <= req_end_index;
      end
      cur_ff        <= cur_in;
      stop_ff       <= stop_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_fill_level = rsp_fill_ff;

endmodule
